// ===== sv/bfsa_pkg.sv =====
// Shared types and constants for the best-fit shared allocator.
// Used by bfsa_ctrl and best_fit_shared_allocator_unit; no dependencies.
`default_nettype none

package bfsa_pkg;

  localparam int DEF_MAX_BLOCKS = 32;
  localparam int DEF_SIZE_BITS  = 16;

  // Fixed field widths at the ports
  localparam int IDX_FW   = 5;
  localparam int SIZE_FW  = 16;
  localparam int SPACE_FW = 16;
  localparam int COUNT_FW = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                operation;
    logic [IDX_FW-1:0]   block_index;
    logic [SIZE_FW-1:0]  size;
    logic [COUNT_FW-1:0] block_count;
  } request_t;

  typedef struct packed {
    logic                allocated;
    logic [IDX_FW-1:0]   chosen_block;
    logic [SPACE_FW-1:0] space_left;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/best_fit_shared_allocator_unit.sv =====
// Best-fit shared allocator over a table of free space per memory block.
// A load beat writes one entry; an allocate beat scans min(block_count,
// MAX_BLOCKS) entries through the single read port of the free-space RAM, one
// entry per cycle, before the chosen entry is written back. A zero count
// finishes like a load. One item is in flight at a time; the output register
// holds a finished result so that the next beat is taken while the result
// waits. Entries must be loaded before any scan reaches them. Depends on
// bfsa_pkg, bfsa_mem and bfsa_ctrl.
`default_nettype none

module best_fit_shared_allocator_unit
  import bfsa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [COUNT_FW-1:0] cfg_data,    // block_count
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [23:0]         in_tdata,    // [4:0] block_index, [20:5] size, rest 0
  input  wire logic                in_tuser,    // operation
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [23:0]         out_tdata    // [0] allocated, [5:1] chosen_block,
                                                // [21:6] space_left, rest 0
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [COUNT_FW-1:0]  block_count_r;
  logic                 out_valid_r;
  result_t              out_res_r;
  request_t             req;
  result_t              res;
  logic                 idle, start, res_valid, res_ready;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [SIZE_BITS-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      block_count_r <= cfg_data;
    end
  end

  assign in_tready = idle;
  assign start     = in_tvalid && in_tready;

  always_comb begin
    req.operation   = in_tuser;
    req.block_index = in_tdata[IDX_FW-1:0];
    req.size        = in_tdata[IDX_FW +: SIZE_FW];
    req.block_count = block_count_r;
  end

  assign res_ready = !out_valid_r || out_tready;

  bfsa_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  bfsa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .idle      (idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.space_left, out_res_r.chosen_block,
                       out_res_r.allocated};

endmodule

`default_nettype wire

// ===== sv/bfsa_mem.sv =====
// Free-space table: one write port, one read port, read data registered.
// Standalone; sized by the parameters handed down from the top level.
`default_nettype none

module bfsa_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfsa_ctrl.sv =====
// Sequencer for the allocator: writes loads; for allocates scans the table, keeps the best fit, writes back.
// Depends on bfsa_pkg and drives the ports of bfsa_mem.
`default_nettype none

module bfsa_ctrl
  import bfsa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS,
  localparam int AW        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire request_t             req,
  output logic                      idle,
  input  wire logic                 res_ready,
  output logic                      res_valid,
  output result_t                   res,
  output logic                      mem_we,
  output logic     [AW-1:0]         mem_waddr,
  output logic     [SIZE_BITS-1:0]  mem_wdata,
  output logic                      mem_re,
  output logic     [AW-1:0]         mem_raddr,
  input  wire logic [SIZE_BITS-1:0] mem_rdata
);

  state_t               state_r, state_nxt;
  logic                 op_r, op_nxt;
  logic [IDX_FW-1:0]    idx_r, idx_nxt;
  logic                 load_ok_r, load_ok_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [AW-1:0]        last_idx_r, last_idx_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 rd_valid_r, rd_valid_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_val_r, best_val_nxt;

  logic [31:0]          cnt32, eff32, last32, size32, idx32, best32, left32;
  logic                 fits;
  logic [SIZE_BITS-1:0] left_val;

  function automatic logic [AW-1:0] idx32_from_reg(input logic [IDX_FW-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[AW-1:0];
  endfunction

  // Clamp the count and form the truncated request
  always_comb begin
    cnt32  = 32'(req.block_count);
    eff32  = (cnt32 > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : cnt32;
    last32 = eff32 - 32'd1;
    size32 = 32'(req.size);
    idx32  = 32'(req.block_index);
  end

  assign fits = rd_valid_r && (mem_rdata >= req_r) &&
                (!found_r || (mem_rdata < best_val_r));
  assign left_val = best_val_r - req_r;
  assign best32   = 32'(best_idx_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (req.operation == OP_LOAD || eff32 == 32'd0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r == last_idx_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_comb begin
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    load_ok_nxt  = load_ok_r;
    req_nxt      = req_r;
    last_idx_nxt = last_idx_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_idx_nxt  = rd_idx_r;
    rd_valid_nxt = (state_r == ST_SCAN);
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    if (state_r == ST_IDLE && start) begin
      op_nxt       = req.operation;
      idx_nxt      = req.block_index;
      load_ok_nxt  = idx32 < 32'(MAX_BLOCKS);
      req_nxt      = size32[SIZE_BITS-1:0];
      last_idx_nxt = last32[AW-1:0];
      rd_idx_nxt   = '0;
      found_nxt    = 1'b0;
      best_idx_nxt = '0;
    end
    if (state_r == ST_SCAN) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
    if (fits) begin
      found_nxt    = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_val_nxt = mem_rdata;
    end
  end

  // Outputs
  always_comb begin
    idle      = (state_r == ST_IDLE);
    mem_re    = (state_r == ST_SCAN);
    mem_raddr = rd_idx_r;
    res_valid = (state_r == ST_FINISH) && res_ready;
    mem_we    = 1'b0;
    mem_waddr = best_idx_r;
    mem_wdata = left_val;
    left32    = 32'(left_val);
    res       = '0;
    if (op_r == OP_LOAD) begin
      mem_waddr        = idx32_from_reg(idx_r);
      mem_wdata        = req_r;
      res.chosen_block = idx_r;
      if (load_ok_r) begin
        left32         = 32'(req_r);
        res.space_left = left32[SPACE_FW-1:0];
      end
      mem_we = res_valid && load_ok_r;
    end else if (found_r) begin
      res.allocated    = 1'b1;
      res.chosen_block = best32[IDX_FW-1:0];
      res.space_left   = left32[SPACE_FW-1:0];
      mem_we           = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_valid_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_valid_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    load_ok_r  <= load_ok_nxt;
    req_r      <= req_nxt;
    last_idx_r <= last_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
  end

  a_write_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FINISH && res_ready))
    else $error("free-space write outside the finish step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (rd_idx_r <= last_idx_r))
    else $error("scan address beyond the blocks in use");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && op_r == OP_ALLOC && found_r) |-> (best_idx_r <= last_idx_r))
    else $error("chosen block beyond the blocks in use");

  a_no_read_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> !rd_valid_r)
    else $error("read data marked valid without a scan");

endmodule

`default_nettype wire
